// ----- rtl/core/bsm_pkg.sv -----
// Shared types, codes and constants for the bank switch mapper.
package bsm_pkg;

  // Bus access kinds carried by the command field.
  typedef enum logic [1:0] {
    CMD_CPU_READ  = 2'd0,
    CMD_CPU_WRITE = 2'd1,
    CMD_PPU_READ  = 2'd2,
    CMD_PPU_WRITE = 2'd3
  } cmd_e;

  // Memory selected by a translated access.
  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_RAM = 3'd1,
    TGT_PRG_ROM = 3'd2,
    TGT_CHR_ROM = 3'd3,
    TGT_VRAM    = 3'd4
  } target_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_PRG_BANK_COUNT   = 1'b0,
    CFG_INIT_MIRROR_VERT = 1'b1
  } cfg_idx_e;

  // Mapper register select codes, address bits 15:12 of a CPU write.
  localparam logic [3:0] SEL_PRG    = 4'hA;
  localparam logic [3:0] SEL_CHR_LO = 4'hB;
  localparam logic [3:0] SEL_CHR_HI = 4'hE;
  localparam logic [3:0] SEL_MIRROR = 4'hF;

  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned MEM_ADDR_W = 17;

  localparam logic [4:0]  PRG_COUNT_RESET = 5'd16;
  localparam logic [4:0]  PRG_COUNT_MIN   = 5'd4;
  localparam logic [4:0]  PRG_COUNT_MAX   = 5'd16;
  localparam logic [3:0]  PRG_BANK_RESET  = 4'd1;

  localparam logic [15:0] ADDR_LATCH_LO_FD = 16'h0FD8;
  localparam logic [15:0] ADDR_LATCH_LO_FE = 16'h0FE8;
  localparam logic [15:0] ADDR_PRG_RAM_LO  = 16'h6000;
  localparam logic [15:0] ADDR_PRG_RAM_HI  = 16'h7FFF;
  localparam logic [15:0] ADDR_PRG_SWITCH  = 16'h8000;
  localparam logic [15:0] ADDR_PRG_FIXED   = 16'hA000;
  localparam logic [15:0] ADDR_NT_LO       = 16'h2000;
  localparam logic [15:0] ADDR_NT_HI       = 16'h3EFF;
  localparam logic [11:0] ADDR_LATCH_HI_FD = 12'hFD8;
  localparam logic [11:0] ADDR_LATCH_HI_FE = 12'hFE8;

  // Mapper register view used by the translation logic.
  typedef struct packed {
    logic [4:0]      prg_bank_count;
    logic [3:0]      prg_bank;
    logic [3:0][4:0] chr_sel;
    logic [1:0]      chr_latch;
    logic            mirror_h;
  } map_state_t;

  // Register updates caused by one item.
  typedef struct packed {
    logic       prg_we;
    logic       chr_we;
    logic [1:0] chr_idx;
    logic       mirror_we;
    logic [4:0] data;
    logic [1:0] latch_we;
    logic [1:0] latch_val;
  } map_upd_t;

  // One result item.
  typedef struct packed {
    target_e         target;
    logic [16:0]     mem_address;
    logic            mem_write;
    logic [7:0]      store_data;
    logic            unmapped;
  } result_t;

endpackage

// ----- rtl/core/bsm_state.sv -----
// Mapper registers: PRG bank, CHR selects, FD/FE latches, mirroring and config.
module bsm_state (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [4:0]             cfg_data_i,
  input  logic                   upd_en_i,
  input  bsm_pkg::map_upd_t      upd_i,
  output bsm_pkg::map_state_t    state_o
);
  import bsm_pkg::*;

  logic [4:0]      prg_count_q;
  logic            init_vert_q;
  logic [3:0]      prg_bank_q;
  logic [3:0][4:0] chr_sel_q;
  logic [1:0]      chr_latch_q;
  logic            mirror_h_q;

  // Configuration writes and item-driven register updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q <= PRG_COUNT_RESET;
      init_vert_q <= 1'b0;
      prg_bank_q  <= PRG_BANK_RESET;
      chr_sel_q   <= '0;
      chr_latch_q <= 2'b11;
      mirror_h_q  <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_PRG_BANK_COUNT: begin
            prg_count_q <= cfg_data_i;
          end
          CFG_INIT_MIRROR_VERT: begin
            init_vert_q <= cfg_data_i[0];
            mirror_h_q  <= ~cfg_data_i[0];
          end
          default: begin
          end
        endcase
      end
      if (upd_en_i) begin
        if (upd_i.prg_we) begin
          prg_bank_q <= upd_i.data[3:0];
        end
        if (upd_i.chr_we) begin
          chr_sel_q[upd_i.chr_idx] <= upd_i.data;
        end
        if (upd_i.mirror_we) begin
          mirror_h_q <= upd_i.data[0];
        end
        for (int i = 0; i < 2; i++) begin
          if (upd_i.latch_we[i]) begin
            chr_latch_q[i] <= upd_i.latch_val[i];
          end
        end
      end
    end
  end

  // The initial mirroring value is kept only as a register image.
  assign state_o.prg_bank_count = prg_count_q;
  assign state_o.prg_bank       = prg_bank_q;
  assign state_o.chr_sel        = chr_sel_q;
  assign state_o.chr_latch      = chr_latch_q;
  assign state_o.mirror_h       = init_vert_q ? mirror_h_q : mirror_h_q;

endmodule

// ----- rtl/core/bsm_xlate.sv -----
// Address translation for one bus access, with the register updates it causes.
module bsm_xlate (
  input  bsm_pkg::cmd_e        cmd_i,
  input  logic [15:0]          addr_i,
  input  logic [7:0]           data_i,
  input  bsm_pkg::map_state_t  state_i,
  output bsm_pkg::result_t     result_o,
  output bsm_pkg::map_upd_t    upd_o
);
  import bsm_pkg::*;

  logic       is_cpu;
  logic       is_wr;
  logic [3:0] sel;
  logic [4:0] count_clamped;
  logic [3:0] fixed_base;
  logic [4:0] chr_bank;
  logic [15:0] fixed_off;

  // Fixed bank base from the clamped bank count.
  always_comb begin
    if (state_i.prg_bank_count < PRG_COUNT_MIN) begin
      count_clamped = PRG_COUNT_MIN;
    end else if (state_i.prg_bank_count > PRG_COUNT_MAX) begin
      count_clamped = PRG_COUNT_MAX;
    end else begin
      count_clamped = state_i.prg_bank_count;
    end
    fixed_base = 4'(count_clamped - 5'd3);
    fixed_off  = addr_i - ADDR_PRG_FIXED;
  end

  assign is_cpu = (cmd_i == CMD_CPU_READ) || (cmd_i == CMD_CPU_WRITE);
  assign is_wr  = (cmd_i == CMD_CPU_WRITE) || (cmd_i == CMD_PPU_WRITE);
  assign sel    = addr_i[15:12];

  // CHR bank for a pattern read, picked by the latch of its half.
  always_comb begin
    if (!addr_i[12]) begin
      chr_bank = state_i.chr_latch[0] ? state_i.chr_sel[1] : state_i.chr_sel[0];
    end else begin
      chr_bank = state_i.chr_latch[1] ? state_i.chr_sel[3] : state_i.chr_sel[2];
    end
  end

  // Window decode.
  always_comb begin
    result_o          = '0;
    result_o.target   = TGT_NONE;
    upd_o             = '0;
    upd_o.data        = data_i[4:0];
    upd_o.chr_idx     = 2'(sel - SEL_CHR_LO);
    if (is_cpu) begin
      if (addr_i >= ADDR_PRG_RAM_LO && addr_i <= ADDR_PRG_RAM_HI) begin
        result_o.target      = TGT_PRG_RAM;
        result_o.mem_address = {4'd0, addr_i[12:0]};
        result_o.mem_write   = is_wr;
        result_o.store_data  = is_wr ? data_i : 8'd0;
      end else if (addr_i >= ADDR_PRG_FIXED && is_wr) begin
        // Mapper register write.
        if (sel == SEL_PRG) begin
          upd_o.prg_we = 1'b1;
        end else if (sel >= SEL_CHR_LO && sel <= SEL_CHR_HI) begin
          upd_o.chr_we = 1'b1;
        end else begin
          upd_o.mirror_we = 1'b1;
        end
      end else if (addr_i >= ADDR_PRG_FIXED) begin
        result_o.target      = TGT_PRG_ROM;
        result_o.mem_address = {fixed_base, 13'd0} + {1'b0, fixed_off};
      end else if (addr_i >= ADDR_PRG_SWITCH && !is_wr) begin
        result_o.target      = TGT_PRG_ROM;
        result_o.mem_address = {state_i.prg_bank, addr_i[12:0]};
      end else begin
        result_o.unmapped = 1'b1;
      end
    end else if (addr_i < ADDR_NT_LO) begin
      if (is_wr) begin
        result_o.unmapped = 1'b1;
      end else begin
        result_o.target      = TGT_CHR_ROM;
        result_o.mem_address = {chr_bank, addr_i[11:0]};
        if (!addr_i[12]) begin
          if (addr_i == ADDR_LATCH_LO_FD) begin
            upd_o.latch_we[0]  = 1'b1;
            upd_o.latch_val[0] = 1'b0;
          end else if (addr_i == ADDR_LATCH_LO_FE) begin
            upd_o.latch_we[0]  = 1'b1;
            upd_o.latch_val[0] = 1'b1;
          end
        end else begin
          if (addr_i[11:3] == ADDR_LATCH_HI_FD[11:3]) begin
            upd_o.latch_we[1]  = 1'b1;
            upd_o.latch_val[1] = 1'b0;
          end else if (addr_i[11:3] == ADDR_LATCH_HI_FE[11:3]) begin
            upd_o.latch_we[1]  = 1'b1;
            upd_o.latch_val[1] = 1'b1;
          end
        end
      end
    end else if (addr_i <= ADDR_NT_HI) begin
      // Nametables: the $3000 mirror only clears bit 12, so bits 11:0 serve.
      result_o.target      = TGT_VRAM;
      result_o.mem_address = state_i.mirror_h ? {6'd0, addr_i[11], addr_i[9:0]}
                                              : {6'd0, addr_i[10:0]};
      result_o.mem_write   = is_wr;
      result_o.store_data  = is_wr ? data_i : 8'd0;
    end else begin
      result_o.unmapped = 1'b1;
    end
  end

endmodule

// ----- rtl/core/bank_switch_mapper_with_chr_latch_top.sv -----
// An accepted item is translated from the input register into the result
// register, from which its result is presented.
// Throughput: one item per cycle unless stalled. While a result waits, the input
// register takes one more item, then holds the input off until the result leaves.
// Reset: asynchronous, active low; empties the pipeline, PRG bank 1, CHR
// selects 0, both latches FE, horizontal mirroring, bank count 16.
module bank_switch_mapper_with_chr_latch_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  target_o,
  output logic [16:0] mem_address_o,
  output logic        mem_write_o,
  output logic [7:0]  store_data_o,
  output logic        unmapped_o
);
  import bsm_pkg::*;

  logic        s1_valid_q;
  cmd_e        s1_cmd_q;
  logic [15:0] s1_addr_q;
  logic [7:0]  s1_data_q;
  logic        out_valid_q;
  result_t     out_q;
  result_t     result_d;
  map_upd_t    upd;
  map_state_t  state;
  logic        out_space;
  logic        s1_fire;
  logic        in_accept;

  assign out_space  = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_space;
  assign in_ready_o = !s1_valid_q || out_space;
  assign in_accept  = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q  <= cmd_e'(command_i);
      s1_addr_q <= address_i;
      s1_data_q <= write_data_i;
    end
  end

  bsm_xlate u_xlate (
    .cmd_i    (s1_cmd_q),
    .addr_i   (s1_addr_q),
    .data_i   (s1_data_q),
    .state_i  (state),
    .result_o (result_d),
    .upd_o    (upd)
  );

  bsm_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .upd_en_i    (s1_fire),
    .upd_i       (upd),
    .state_o     (state)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign target_o      = out_q.target;
  assign mem_address_o = out_q.mem_address;
  assign mem_write_o   = out_q.mem_write;
  assign store_data_o  = out_q.store_data;
  assign unmapped_o    = out_q.unmapped;

endmodule

// ----- rtl/core/bsm_checker.sv -----
// Port-level checks for the mapper top level, with the bind that attaches them.
module bsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  target_o,
  input logic [16:0] mem_address_o,
  input logic        mem_write_o,
  input logic [7:0]  store_data_o,
  input logic        unmapped_o
);
  import bsm_pkg::*;

  // A stalled item holds its target, address and unmapped flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(target_o)
      && $stable(mem_address_o) && $stable(unmapped_o))
    else $error("result changed while stalled");

  // No target means no address and no write.
  a_none_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_o == TGT_NONE |-> mem_address_o == '0 && !mem_write_o)
    else $error("address or write on an item with no target");

  // Store data is zero unless the item writes memory.
  a_store_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mem_write_o |-> store_data_o == '0)
    else $error("store data set on a non-write item");

  // Only RAM targets are written.
  a_write_tgt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mem_write_o |->
      (target_o == TGT_PRG_RAM || target_o == TGT_VRAM) && !unmapped_o)
    else $error("write to a read-only or unmapped target");

endmodule

bind bank_switch_mapper_with_chr_latch_top bsm_checker u_bsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .target_o      (target_o),
  .mem_address_o (mem_address_o),
  .mem_write_o   (mem_write_o),
  .store_data_o  (store_data_o),
  .unmapped_o    (unmapped_o)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the bank switch mapper with CHR latches.
`timescale 1ns / 1ps

import bsm_pkg::*;

// Tracks the mapper registers and holds the translations still to come.
class bank_map_board;
  localparam int unsigned VRAM_BYTES    = 2048;
  localparam int unsigned PRG_RAM_BYTES = 8192;
  localparam int unsigned REPORT_LIMIT  = 10;

  logic [4:0]  bank_count;
  logic [3:0]  prg_bank;
  logic [4:0]  chr_sel [4];
  logic        chr_latch [2];
  logic        mirror_h;
  result_t     pending_xlat [$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned reg_writes;
  int unsigned latch_hits;
  int unsigned accesses;

  function new();
    bank_count = PRG_COUNT_RESET;
    prg_bank   = PRG_BANK_RESET;
    foreach (chr_sel[i]) chr_sel[i] = '0;
    chr_latch[0] = 1'b1;
    chr_latch[1] = 1'b1;
    mirror_h     = 1'b1;
    mismatches   = 0;
    checked      = 0;
    reg_writes   = 0;
    latch_hits   = 0;
    accesses     = 0;
  endfunction

  // A write of the mirroring default also reloads the live mirroring bit.
  function void write_cfg(cfg_idx_e idx, logic [4:0] value);
    if (idx == CFG_PRG_BANK_COUNT) begin
      bank_count = value;
    end else begin
      mirror_h = ~value[0];
    end
  endfunction

  // Nametable space folds onto 2KB of VRAM.
  function logic [10:0] vram_offset(logic [15:0] a);
    logic [15:0] fold;
    logic [15:0] off;
    fold = (a >= 16'h3000) ? a - 16'h1000 : a;
    if (mirror_h) begin
      off = (fold & 16'h03FF) + ((fold < 16'h2800) ? 16'h0000 : 16'h0400);
    end else begin
      off = fold & 16'h07FF;
    end
    return off[10:0] & 11'(VRAM_BYTES - 1);
  endfunction

  // Work out the translation of one accepted access and update the registers.
  function void note_access(cmd_e cmd, logic [15:0] a, logic [7:0] d);
    result_t     r;
    logic        wr;
    logic [3:0]  sel;
    logic [4:0]  bank;
    int unsigned n;
    r = '0;
    r.target = TGT_NONE;
    accesses++;
    if (cmd == CMD_CPU_READ || cmd == CMD_CPU_WRITE) begin
      wr = (cmd == CMD_CPU_WRITE);
      if (a >= ADDR_PRG_RAM_LO && a <= ADDR_PRG_RAM_HI) begin
        r.target      = TGT_PRG_RAM;
        r.mem_address = 17'((a - ADDR_PRG_RAM_LO) & (PRG_RAM_BYTES - 1));
        r.mem_write   = wr;
        r.store_data  = wr ? d : 8'h00;
      end else if (a >= ADDR_PRG_FIXED && wr) begin
        sel = a[15:12];
        reg_writes++;
        if (sel == SEL_PRG) begin
          prg_bank = d[3:0];
        end else if (sel >= SEL_CHR_LO && sel <= SEL_CHR_HI) begin
          chr_sel[sel - SEL_CHR_LO] = d[4:0];
        end else begin
          mirror_h = d[0];
        end
      end else if (a >= ADDR_PRG_FIXED) begin
        n = bank_count;
        if (n < PRG_COUNT_MIN) n = PRG_COUNT_MIN;
        if (n > PRG_COUNT_MAX) n = PRG_COUNT_MAX;
        r.target      = TGT_PRG_ROM;
        r.mem_address = 17'((n - 3) * 32'h2000 + (a - ADDR_PRG_FIXED));
      end else if (a >= ADDR_PRG_SWITCH && !wr) begin
        r.target      = TGT_PRG_ROM;
        r.mem_address = 17'(prg_bank * 32'h2000 + (a - ADDR_PRG_SWITCH));
      end else begin
        r.unmapped = 1'b1;
      end
    end else if (a < ADDR_NT_LO) begin
      if (cmd == CMD_PPU_WRITE) begin
        r.unmapped = 1'b1;
      end else if (a < 16'h1000) begin
        // The read sees the latch as it was, then the trigger sets it.
        bank          = chr_sel[chr_latch[0] ? 1 : 0];
        r.target      = TGT_CHR_ROM;
        r.mem_address = 17'(bank * 32'h1000 + a);
        if (a == ADDR_LATCH_LO_FD) begin
          chr_latch[0] = 1'b0;
          latch_hits++;
        end else if (a == ADDR_LATCH_LO_FE) begin
          chr_latch[0] = 1'b1;
          latch_hits++;
        end
      end else begin
        bank          = chr_sel[chr_latch[1] ? 3 : 2];
        r.target      = TGT_CHR_ROM;
        r.mem_address = 17'(bank * 32'h1000 + (a - 16'h1000));
        if (a >= {4'h1, ADDR_LATCH_HI_FD} && a <= {4'h1, ADDR_LATCH_HI_FD} + 16'd7) begin
          chr_latch[1] = 1'b0;
          latch_hits++;
        end else if (a >= {4'h1, ADDR_LATCH_HI_FE} &&
                     a <= {4'h1, ADDR_LATCH_HI_FE} + 16'd7) begin
          chr_latch[1] = 1'b1;
          latch_hits++;
        end
      end
    end else if (a <= ADDR_NT_HI) begin
      r.target      = TGT_VRAM;
      r.mem_address = 17'(vram_offset(a));
      r.mem_write   = (cmd == CMD_PPU_WRITE);
      r.store_data  = (cmd == CMD_PPU_WRITE) ? d : 8'h00;
    end else begin
      r.unmapped = 1'b1;
    end
    pending_xlat.push_back(r);
  endfunction

  // Compare one delivered translation with the oldest one predicted.
  function void check_translation(result_t got);
    result_t want;
    logic    bad;
    checked++;
    if (pending_xlat.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("ERROR: unexpected item target=%0d addr=%05h", got.target, got.mem_address);
      end
      return;
    end
    want = pending_xlat.pop_front();
    bad  = (got.target !== want.target) || (got.mem_address !== want.mem_address) ||
           (got.mem_write !== want.mem_write) || (got.store_data !== want.store_data) ||
           (got.unmapped !== want.unmapped);
    if (bad) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("ERROR: item %0d expected tgt=%0d addr=%05h wr=%b data=%02h unm=%b",
                 checked, want.target, want.mem_address, want.mem_write,
                 want.store_data, want.unmapped);
        $display("       actual   tgt=%0d addr=%05h wr=%b data=%02h unm=%b",
                 got.target, got.mem_address, got.mem_write, got.store_data,
                 got.unmapped);
      end
    end
  endfunction
endclass

module tb;
  localparam int unsigned SEG_ITEMS = 272;
  localparam int unsigned SEGMENTS  = 7;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic        cfg_index_i  = 1'b0;
  logic [4:0]  cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i    = '0;
  logic [15:0] address_i    = '0;
  logic [7:0]  write_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [2:0]  target_o;
  logic [16:0] mem_address_o;
  logic        mem_write_o;
  logic [7:0]  store_data_o;
  logic        unmapped_o;

  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 66;
  int unsigned cfg_settings  = 0;

  bank_map_board board = new();

  bank_switch_mapper_with_chr_latch_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .target_o     (target_o),
    .mem_address_o(mem_address_o),
    .mem_write_o  (mem_write_o),
    .store_data_o (store_data_o),
    .unmapped_o   (unmapped_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("bank_switch_mapper_with_chr_latch_top verification failed");
    $finish;
  end

  // Result side: check every delivered item and stall at random.
  always @(posedge clk_i) begin
    result_t got;
    if (out_valid_o && out_ready_i) begin
      got.target      = target_e'(target_o);
      got.mem_address = mem_address_o;
      got.mem_write   = mem_write_o;
      got.store_data  = store_data_o;
      got.unmapped    = unmapped_o;
      board.check_translation(got);
    end
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Present one access, with an optional random gap, and wait until it is taken.
  task automatic send_access(cmd_e cmd, logic [15:0] a, logic [7:0] d);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    address_i    <= a;
    write_data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_access(cmd, a, d);
  endtask

  // Hold the input off until every predicted item has been delivered.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending_xlat.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Configuration writes happen only with the pipeline empty.
  task automatic write_reg(cfg_idx_e idx, logic [4:0] value);
    drain_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_cfg(idx, value);
  endtask

  // Random access biased toward register writes, latch triggers and windows.
  function automatic void pick_access(output cmd_e cmd, output logic [15:0] a,
                                      output logic [7:0] d);
    int unsigned r;
    r = $urandom_range(0, 99);
    d = 8'($urandom_range(0, 255));
    if (r < 15) begin
      cmd = CMD_CPU_WRITE;
      a   = 16'($urandom_range(16'hA000, 16'hFFFF));
    end else if (r < 30) begin
      cmd = CMD_CPU_READ;
      a   = 16'($urandom_range(16'h8000, 16'hFFFF));
    end else if (r < 40) begin
      cmd = cmd_e'($urandom_range(0, 1));
      a   = 16'($urandom_range(16'h6000, 16'h7FFF));
    end else if (r < 58) begin
      cmd = CMD_PPU_READ;
      a   = 16'($urandom_range(16'h0000, 16'h1FFF));
    end else if (r < 72) begin
      cmd = CMD_PPU_READ;
      case ($urandom_range(0, 3))
        0: a = ADDR_LATCH_LO_FD;
        1: a = ADDR_LATCH_LO_FE;
        2: a = {4'h1, ADDR_LATCH_HI_FD} + 16'($urandom_range(0, 7));
        default: a = {4'h1, ADDR_LATCH_HI_FE} + 16'($urandom_range(0, 7));
      endcase
    end else if (r < 86) begin
      cmd = cmd_e'($urandom_range(2, 3));
      a   = 16'($urandom_range(16'h2000, 16'h3FFF));
    end else begin
      cmd = cmd_e'($urandom_range(0, 3));
      a   = 16'($urandom_range(0, 16'hFFFF));
    end
  endfunction

  // Directed accesses over every window, register and latch trigger.
  task automatic run_directed();
    send_access(CMD_CPU_READ,  16'h0000, 8'h00);
    send_access(CMD_CPU_WRITE, 16'h5FFF, 8'hFF);
    send_access(CMD_CPU_WRITE, ADDR_PRG_RAM_LO, 8'hA5);
    send_access(CMD_CPU_READ,  ADDR_PRG_RAM_HI, 8'h3C);
    send_access(CMD_CPU_READ,  ADDR_PRG_SWITCH, 8'h00);
    send_access(CMD_CPU_WRITE, 16'h9FFF, 8'h77);
    send_access(CMD_CPU_READ,  ADDR_PRG_FIXED, 8'h00);
    send_access(CMD_CPU_READ,  16'hFFFF, 8'h00);
    send_access(CMD_CPU_WRITE, ADDR_PRG_FIXED, 8'hFF);
    send_access(CMD_CPU_READ,  16'h9FFF, 8'h00);
    send_access(CMD_CPU_WRITE, 16'hB000, 8'h1F);
    send_access(CMD_CPU_WRITE, 16'hC000, 8'h0A);
    send_access(CMD_CPU_WRITE, 16'hDFFF, 8'h15);
    send_access(CMD_CPU_WRITE, 16'hE000, 8'h03);
    send_access(CMD_PPU_READ,  ADDR_LATCH_LO_FD, 8'h00);
    send_access(CMD_PPU_READ,  16'h0000, 8'h00);
    send_access(CMD_PPU_READ,  ADDR_LATCH_LO_FE, 8'h00);
    send_access(CMD_PPU_READ,  16'h1FDF, 8'h00);
    send_access(CMD_PPU_READ,  16'h1000, 8'h00);
    send_access(CMD_PPU_READ,  16'h1FE8, 8'h00);
    send_access(CMD_PPU_WRITE, 16'h1FFF, 8'h99);
    send_access(CMD_PPU_WRITE, ADDR_NT_LO, 8'h5A);
    send_access(CMD_PPU_READ,  16'h2C01, 8'h00);
    send_access(CMD_CPU_WRITE, 16'hF000, 8'h00);
    send_access(CMD_PPU_WRITE, ADDR_NT_HI, 8'hC3);
    send_access(CMD_PPU_READ,  16'h3F00, 8'h00);
    send_access(CMD_PPU_READ,  16'hFFFF, 8'h00);
    send_access(CMD_CPU_WRITE, 16'hFFFF, 8'h01);
  endtask

  // Main sequence: reset, directed part, then random segments per setting.
  initial begin
    cmd_e        cmd;
    logic [15:0] a;
    logic [7:0]  d;
    logic [4:0]  seg_count [SEGMENTS];
    seg_count = '{5'd4, 5'd16, 5'd31, 5'd0, 5'd3, 5'd17, 5'd9};
    seg_count[6] = 5'($urandom_range(5, 15));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 30;
        recv_idle_pct = 66;
      end else if (seg < 4) begin
        send_idle_pct = 66;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_PRG_BANK_COUNT, seg_count[seg]);
      write_reg(CFG_INIT_MIRROR_VERT, 5'(seg % 2 == 0));
      cfg_settings++;
      for (int i = 0; i < SEG_ITEMS; i++) begin
        pick_access(cmd, a, d);
        send_access(cmd, a, d);
        // Now and then let the pipeline run dry mid-stream.
        if ($urandom_range(0, 149) == 0) begin
          drain_pipeline();
        end
      end
    end
    drain_pipeline();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d accesses, %0d mapper register writes, %0d latch triggers,",
             board.accesses, board.reg_writes, board.latch_hits);
    $display("over %0d configuration settings; %0d items checked, %0d mismatches.",
             cfg_settings, board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending_xlat.size() == 0) begin
      $display("bank_switch_mapper_with_chr_latch_top verification clean");
    end else begin
      $display("bank_switch_mapper_with_chr_latch_top verification failed");
    end
    $finish;
  end
endmodule

// ----- bank_switch_mapper_with_chr_latch_top.f -----
rtl/core/bsm_pkg.sv
rtl/core/bsm_state.sv
rtl/core/bsm_xlate.sv
rtl/core/bank_switch_mapper_with_chr_latch_top.sv
rtl/core/bsm_checker.sv
tb/tb.sv
